FILE: rtl/core/nas_pkg.sv
// ----------------------------------------------------------------------------
// nas_pkg: shared types and constants of the next-alarm selector
// Entry, query and scan token layouts, time constants and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nas_pkg;

  localparam int ENTRIES      = 8;
  localparam int IDX_W        = 4;
  localparam int MIN_PER_HOUR = 60;
  localparam int MIN_PER_DAY  = 1440;
  localparam int MIN_PER_WEEK = 10080;
  localparam int LAST_WEEKDAY = 6;
  localparam int BEST_INIT    = MIN_PER_WEEK + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] KIND_HOURLY = 2'd0;
  localparam logic [1:0] KIND_DAILY  = 2'd1;

  typedef struct packed {
    logic       active;
    logic [1:0] kind;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
  } entry_t;

  // Current time, prepared once per query and broadcast to every cell
  typedef struct packed {
    logic [10:0] n;       // hour*60 + minute
    logic [5:0]  nmod;    // minute mod 60
    logic [13:0] n_week;  // n + weekday*1440
    logic [2:0]  wday;
  } query_t;

  // Running best, handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [13:0]      best;
    logic             by_day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [2:0]       day_code;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/core/nas_cell.sv
// ----------------------------------------------------------------------------
// nas_cell: one alarm slot of the scan chain
// Holds one entry, computes its wait for the passing query and replaces the
// running best when the wait is valid and strictly smaller.
// ----------------------------------------------------------------------------
`default_nettype none

module nas_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [nas_pkg::IDX_W-1:0] cell_idx,
  input  wire logic                     wr_en,
  input  wire nas_pkg::entry_t          wr_entry,
  input  wire nas_pkg::query_t          query,
  input  wire logic                     tok_vin,
  input  wire nas_pkg::token_t          tok_in,
  output logic                          tok_vout,
  output nas_pkg::token_t               tok_out
);
  import nas_pkg::*;

  logic        active_r;
  entry_t      ent_r;
  logic [10:0] a_r;
  logic [5:0]  amod_r;
  logic [13:0] abase_r;
  logic [2:0]  code_r;

  logic [10:0] a_wr;
  logic [5:0]  amod_wr;
  logic [13:0] abase_wr;
  logic [2:0]  code_wr;

  logic [14:0] a1;
  logic [14:0] x;
  logic [13:0] nref;
  logic [14:0] w;
  logic        w_ok;
  logic        hit;
  token_t      tok_nxt;

  // Time-of-entry terms are fixed per entry, so they are formed at write time
  always_comb begin
    a_wr     = 11'(wr_entry.hour) * 11'(MIN_PER_HOUR) + 11'(wr_entry.minute);
    amod_wr  = (wr_entry.minute >= 6'(MIN_PER_HOUR)) ?
               wr_entry.minute - 6'(MIN_PER_HOUR) : wr_entry.minute;
    abase_wr = 14'(a_wr) + 14'(wr_entry.weekday) * 14'(MIN_PER_DAY);
    if (!wr_entry.kind[1]) begin
      code_wr = 3'd0;
    end else if (wr_entry.weekday >= 3'(LAST_WEEKDAY)) begin
      code_wr = 3'd0;
    end else begin
      code_wr = wr_entry.weekday + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (wr_en) begin
      active_r <= wr_entry.active;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r   <= wr_entry;
      a_r     <= a_wr;
      amod_r  <= amod_wr;
      abase_r <= abase_wr;
      code_r  <= code_wr;
    end
  end

  // Wait is x - nref, valid when x > nref
  always_comb begin
    a1 = 15'd0;
    case (ent_r.kind)
      KIND_HOURLY: begin
        if (a_r > query.n) begin
          x    = 15'(a_r);
          nref = 14'(query.n);
        end else begin
          // next hourly hit depends only on the minutes mod 60
          x    = 15'(amod_r) + ((amod_r > query.nmod) ? 15'd0 : 15'(MIN_PER_HOUR));
          nref = 14'(query.nmod);
        end
      end
      KIND_DAILY: begin
        x    = 15'(a_r) + ((a_r > query.n) ? 15'd0 : 15'(MIN_PER_DAY));
        nref = 14'(query.n);
      end
      default: begin
        a1   = 15'(abase_r) +
               ((query.wday > ent_r.weekday) ? 15'(MIN_PER_WEEK) : 15'd0);
        x    = a1 + ((a1 > 15'(query.n_week)) ? 15'd0 : 15'(MIN_PER_WEEK));
        nref = query.n_week;
      end
    endcase
    w_ok = x > 15'(nref);
    w    = x - 15'(nref);
    hit  = tok_vin && active_r && w_ok && (w < 15'(tok_in.best));

    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.idx      = cell_idx;
      tok_nxt.best     = w[13:0];
      tok_nxt.by_day   = ent_r.kind[1];
      tok_nxt.hour     = ent_r.hour;
      tok_nxt.minute   = ent_r.minute;
      tok_nxt.day_code = code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vout <= 1'b0;
    end else begin
      tok_vout <= tok_vin;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/next_alarm_selector.sv
// ----------------------------------------------------------------------------
// next_alarm_selector: nearest alarm search over a small alarm table
// A chain of slot cells; a query token walks the chain one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   in_opcode write: stores one entry in slot in_entry_index in that cycle;
//     no result, busy stays low, the next item may follow at once.
//   in_opcode query: the current time is latched and a token enters the
//     first cell; it moves one cell per cycle, through the ENTRIES cell
//     registers and then the result registers, and the result is on the
//     out_ ports, marked by out_strobe, for one cycle.
//     busy is high until the result is registered; a new item may be taken
//     in the cycle the result is shown. A query is never taken while
//     one is still in the cell chain.
//   Results cannot be held off: the receiver must take out_strobe as it
//   comes.
//   Reset (rst_n low, synchronous) marks every slot inactive and drops any
//   query in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module next_alarm_selector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [2:0]  in_entry_index,
  input  wire logic        in_entry_active,
  input  wire logic [1:0]  in_entry_kind,
  input  wire logic [4:0]  in_entry_hour,
  input  wire logic [5:0]  in_entry_minute,
  input  wire logic [2:0]  in_entry_weekday,
  input  wire logic [4:0]  in_now_hour,
  input  wire logic [5:0]  in_now_minute,
  input  wire logic [2:0]  in_now_weekday,
  output logic             out_strobe,
  output logic             out_found,
  output logic [3:0]       out_next_index,
  output logic [13:0]      out_minutes_until,
  output logic             out_match_by_day,
  output logic [4:0]       out_alarm_hour,
  output logic [5:0]       out_alarm_minute,
  output logic [2:0]       out_alarm_day_code
);
  import nas_pkg::*;

  logic         busy_r;
  logic         busy_nxt;
  logic         accept;
  logic         q_accept;
  logic         q_valid_r;
  query_t       query_r;
  query_t       query_nxt;
  entry_t       wr_entry;
  token_t       tok_init;
  logic [ENTRIES-1:0] tok_v;
  token_t       tok [ENTRIES];

  logic         strobe_r;
  logic         found_r;
  logic [3:0]   idx_r;
  logic [13:0]  minutes_r;
  logic         by_day_r;
  logic [4:0]   hour_r;
  logic [5:0]   minute_r;
  logic [2:0]   code_r;

  assign accept   = start && !busy_r;
  assign q_accept = accept && (in_opcode == OP_QUERY);

  assign wr_entry = '{active:  in_entry_active,
                      kind:    in_entry_kind,
                      hour:    in_entry_hour,
                      minute:  in_entry_minute,
                      weekday: in_entry_weekday};

  always_comb begin
    query_nxt.n      = 11'(in_now_hour) * 11'(MIN_PER_HOUR) + 11'(in_now_minute);
    query_nxt.nmod   = (in_now_minute >= 6'(MIN_PER_HOUR)) ?
                       in_now_minute - 6'(MIN_PER_HOUR) : in_now_minute;
    query_nxt.n_week = 14'(query_nxt.n) + 14'(in_now_weekday) * 14'(MIN_PER_DAY);
    query_nxt.wday   = in_now_weekday;
  end

  always_comb begin
    tok_init          = '0;
    tok_init.idx      = IDX_W'(ENTRIES);
    tok_init.best     = 14'(BEST_INIT);
  end

  always_comb begin
    busy_nxt = busy_r;
    if (q_accept) begin
      busy_nxt = 1'b1;
    end else if (tok_v[ENTRIES-1]) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      q_valid_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      q_valid_r <= q_accept;
      strobe_r  <= tok_v[ENTRIES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (q_accept) begin
      query_r <= query_nxt;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      nas_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(gi)),
        .wr_en    (accept && (in_opcode == OP_WRITE) &&
                   (IDX_W'(in_entry_index) == IDX_W'(gi))),
        .wr_entry (wr_entry),
        .query    (query_r),
        .tok_vin  ((gi == 0) ? q_valid_r : tok_v[(gi == 0) ? 0 : gi - 1]),
        .tok_in   ((gi == 0) ? tok_init : tok[(gi == 0) ? 0 : gi - 1]),
        .tok_vout (tok_v[gi]),
        .tok_out  (tok[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (tok_v[ENTRIES-1]) begin
      found_r   <= tok[ENTRIES-1].found;
      idx_r     <= tok[ENTRIES-1].idx;
      minutes_r <= tok[ENTRIES-1].found ? tok[ENTRIES-1].best : 14'd0;
      by_day_r  <= tok[ENTRIES-1].by_day;
      hour_r    <= tok[ENTRIES-1].hour;
      minute_r  <= tok[ENTRIES-1].minute;
      code_r    <= tok[ENTRIES-1].day_code;
    end
  end

  assign busy               = busy_r;
  assign out_strobe         = strobe_r;
  assign out_found          = found_r;
  assign out_next_index     = idx_r;
  assign out_minutes_until  = minutes_r;
  assign out_match_by_day   = by_day_r;
  assign out_alarm_hour     = hour_r;
  assign out_alarm_minute   = minute_r;
  assign out_alarm_day_code = code_r;

`ifndef ASSERT_OFF
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({q_valid_r, tok_v}))
    else $error("more than one query token in the chain");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid_r || (tok_v != '0)) |-> busy_r)
    else $error("query in flight while not busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    q_accept |-> ##(ENTRIES + 2) strobe_r)
    else $error("query result missing at expected cycle");

  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && found_r) |-> ((minutes_r != 14'd0) &&
                               (minutes_r <= 14'(MIN_PER_WEEK))))
    else $error("selected wait out of range");

  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !found_r) |-> ((idx_r == IDX_W'(ENTRIES)) && (minutes_r == 14'd0)))
    else $error("empty result not reported as none");
`endif

endmodule

`default_nettype wire
